@@ design/gtb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GeLU tanh backward package
// Shared widths, fixed-point constants, payload types, rounding and reciprocal helpers.
// ----------------------------------------------------------------------------
package gtb_pkg;

  localparam int DataWidth  = 16;
  localparam int FracBits   = 12;
  localparam int Iq         = 28;
  localparam int XsqWidth   = 31;
  localparam int Y1Width    = 36;
  localparam int MagWidth   = 35;
  localparam int Y2Width    = 37;
  localparam int KWidth     = 8;
  localparam int RWidth     = 28;
  localparam int PWidth     = 29;
  localparam int NumWidth   = 57;
  localparam int DenWidth   = 30;
  localparam int DerivWidth = 37;
  localparam int GWidth     = 38;
  localparam int TermWidth  = 27;
  localparam int SumWidth   = 28;
  localparam int LoBits     = 18;
  localparam int ExpSteps   = 11;
  localparam int ExpKLimit  = 40;
  localparam int DivSteps   = 29;
  localparam int RcpLn2Shift = 40;
  localparam int RcpNShift  = 31;

  localparam logic signed [31:0] K3Q = -32'sd428361012;
  localparam logic signed [25:0] K4Q = -26'sd19154163;
  localparam logic signed [26:0] K5Q = -27'sd57462488;
  localparam logic [27:0] Ln2Q    = 28'd186065280;
  localparam logic [12:0] RcpLn2  = 13'd5909;
  localparam logic [PWidth-1:0] OneQ = PWidth'(1) << Iq;

  typedef struct packed {
    logic signed [Y2Width-1:0]   y2;
    logic signed [DataWidth-1:0] dy;
    logic signed [DataWidth-1:0] dx;
    logic                        last;
  } side_t;

  typedef struct packed {
    logic                neg;
    logic [MagWidth-1:0] mag;
    side_t               side;
  } item_t;

  typedef struct packed {
    logic              neg;
    logic [KWidth-1:0] k;
    logic [RWidth-1:0] r;
    side_t             side;
  } exp_t;

  // Shift right with rounding to nearest, ties away from zero.
  function automatic logic signed [79:0] rnd_q(input logic signed [79:0] v,
                                               input int unsigned sh);
    logic [79:0] mag;
    logic [79:0] half;
    half = 80'(1) << (sh - 1);
    mag  = v[79] ? 80'(-v) : 80'(v);
    mag  = (mag + half) >> sh;
    return v[79] ? -$signed(mag) : $signed(mag);
  endfunction

  // Reciprocal of a small divisor, scaled by two to the RcpNShift.
  function automatic logic [31:0] rcp_n(input logic [3:0] n);
    logic [31:0] m;
    unique case (n)
      4'd1:    m = 32'd2147483648;
      4'd2:    m = 32'd1073741824;
      4'd3:    m = 32'd715827882;
      4'd4:    m = 32'd536870912;
      4'd5:    m = 32'd429496729;
      4'd6:    m = 32'd357913941;
      4'd7:    m = 32'd306783378;
      4'd8:    m = 32'd268435456;
      4'd9:    m = 32'd238609294;
      4'd10:   m = 32'd214748364;
      4'd11:   m = 32'd195225786;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

@@ design/gtb_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GeLU tanh backward front end
// Takes items, evaluates the two cubic polynomials and classifies the sign.
// ----------------------------------------------------------------------------
module gtb_front (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  output logic                                       busy_o,
  input  wire logic signed [gtb_pkg::DataWidth-1:0] x_i,
  input  wire logic signed [gtb_pkg::DataWidth-1:0] dy_i,
  input  wire logic signed [gtb_pkg::DataWidth-1:0] dx_i,
  input  wire logic                                  last_i,
  input  wire logic                                  full_i,
  output logic                                       push_o,
  output gtb_pkg::item_t                             item_o
);

  logic stall, en;
  logic va_q, vb_q, vc_q, vd_q, ve_q;
  logic signed [gtb_pkg::DataWidth-1:0] xa_q, xb_q, xc_q, xd_q;
  logic signed [gtb_pkg::DataWidth-1:0] dya_q, dyb_q, dyc_q, dyd_q;
  logic signed [gtb_pkg::DataWidth-1:0] dxa_q, dxb_q, dxc_q, dxd_q;
  logic lasta_q, lastb_q, lastc_q, lastd_q;
  logic [gtb_pkg::XsqWidth-1:0] xsq_q;
  logic signed [57:0] m4_q, m5_q;
  logic signed [31:0] t1_q;
  logic signed [32:0] t2_q;
  gtb_pkg::item_t item_q;

  logic signed [31:0] sq;
  logic [gtb_pkg::XsqWidth-1:0] xsq_d;
  logic signed [57:0] m4_d, m5_d;
  logic signed [31:0] t1_d;
  logic signed [32:0] t2_d;
  logic signed [gtb_pkg::Y1Width-1:0] y1;
  gtb_pkg::item_t item_d;

  assign stall  = ve_q & full_i;
  assign en     = !stall;
  assign busy_o = stall;
  assign push_o = ve_q & !full_i;
  assign item_o = item_q;

  always_comb begin
    sq    = 32'(xa_q) * 32'(xa_q);
    xsq_d = sq[gtb_pkg::XsqWidth-1:0];
    m4_d  = 58'(gtb_pkg::K4Q) * 58'($signed({1'b0, xsq_q}));
    m5_d  = 58'(gtb_pkg::K5Q) * 58'($signed({1'b0, xsq_q}));
    t1_d  = gtb_pkg::K3Q + 32'(gtb_pkg::rnd_q(80'(m4_q), 24));
    t2_d  = 33'(gtb_pkg::K3Q) + 33'(gtb_pkg::rnd_q(80'(m5_q), 24));
    y1    = gtb_pkg::Y1Width'(gtb_pkg::rnd_q(80'(48'(xd_q) * 48'(t1_q)), 12));
    item_d.neg       = y1[gtb_pkg::Y1Width-1];
    item_d.mag       = y1[gtb_pkg::Y1Width-1] ? gtb_pkg::MagWidth'(-y1)
                                               : gtb_pkg::MagWidth'(y1);
    item_d.side.y2   = gtb_pkg::Y2Width'(gtb_pkg::rnd_q(80'(50'(xd_q) * 50'(t2_q)), 12));
    item_d.side.dy   = dyd_q;
    item_d.side.dx   = dxd_q;
    item_d.side.last = lastd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (en) begin
      va_q <= start_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xa_q    <= x_i;
      dya_q   <= dy_i;
      dxa_q   <= dx_i;
      lasta_q <= last_i;
      xb_q    <= xa_q;
      dyb_q   <= dya_q;
      dxb_q   <= dxa_q;
      lastb_q <= lasta_q;
      xsq_q   <= xsq_d;
      xc_q    <= xb_q;
      dyc_q   <= dyb_q;
      dxc_q   <= dxb_q;
      lastc_q <= lastb_q;
      m4_q    <= m4_d;
      m5_q    <= m5_d;
      xd_q    <= xc_q;
      dyd_q   <= dyc_q;
      dxd_q   <= dxc_q;
      lastd_q <= lastc_q;
      t1_q    <= t1_d;
      t2_q    <= t2_d;
      item_q  <= item_d;
    end
  end

endmodule
`default_nettype wire

@@ design/gtb_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GeLU tanh backward item queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module gtb_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire gtb_pkg::item_t item_i,
  input  wire logic           pop_i,
  output gtb_pkg::item_t      item_o,
  output logic                full_o,
  output logic                empty_o
);

  gtb_pkg::item_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("Queue written while full.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("Queue read while empty.");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> !empty_o) else $error("Queue lost a written item.");

  a_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_q == rd_q))
    else $error("Queue pointers disagree with the count.");

endmodule
`default_nettype wire

@@ design/gtb_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GeLU tanh backward divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module gtb_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             vld_i,
  input  wire logic [gtb_pkg::NumWidth-1:0]     num_i,
  input  wire logic [gtb_pkg::DenWidth-1:0]     den_i,
  input  wire gtb_pkg::side_t                   side_i,
  output logic                                  vld_o,
  output logic [gtb_pkg::DivSteps-1:0]          quo_o,
  output gtb_pkg::side_t                        side_o
);

  localparam int Steps = gtb_pkg::DivSteps;

  logic                           vld_s  [Steps+1];
  logic [Steps-1:0]               rem_s  [Steps+1];
  logic [Steps-1:0]               low_s  [Steps+1];
  logic [Steps-1:0]               quo_s  [Steps+1];
  logic [gtb_pkg::DenWidth-1:0]   den_s  [Steps+1];
  gtb_pkg::side_t                 side_s [Steps+1];

  assign vld_s[0]  = vld_i;
  assign rem_s[0]  = Steps'(num_i[gtb_pkg::NumWidth-1:Steps]);
  assign low_s[0]  = num_i[Steps-1:0];
  assign quo_s[0]  = '0;
  assign den_s[0]  = den_i;
  assign side_s[0] = side_i;

  for (genvar j = 0; j < Steps; j++) begin : g_stage
    logic [Steps:0]   remx;
    logic             ge;
    logic [Steps-1:0] rem_d;
    logic             v_q;
    logic [Steps-1:0] rem_q, low_q, quo_q;
    logic [gtb_pkg::DenWidth-1:0] den_q;
    gtb_pkg::side_t   side_q;

    always_comb begin
      remx  = {rem_s[j], low_s[j][Steps-1]};
      ge    = (remx >= den_s[j]);
      rem_d = ge ? Steps'(remx - den_s[j]) : remx[Steps-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else begin
        v_q <= vld_s[j];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q  <= rem_d;
      low_q  <= {low_s[j][Steps-2:0], 1'b0};
      quo_q  <= {quo_s[j][Steps-2:0], ge};
      den_q  <= den_s[j];
      side_q <= side_s[j];
    end

    assign vld_s[j+1]  = v_q;
    assign rem_s[j+1]  = rem_q;
    assign low_s[j+1]  = low_q;
    assign quo_s[j+1]  = quo_q;
    assign den_s[j+1]  = den_q;
    assign side_s[j+1] = side_q;
  end

  assign vld_o  = vld_s[Steps];
  assign quo_o  = quo_s[Steps];
  assign side_o = side_s[Steps];

endmodule
`default_nettype wire

@@ design/gtb_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GeLU tanh backward back end
// Exponential, sigmoid division, derivative and saturating accumulation.
// ----------------------------------------------------------------------------
module gtb_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            vld_i,
  input  wire gtb_pkg::item_t                  item_i,
  output logic                                 done_o,
  output logic signed [gtb_pkg::DataWidth-1:0] grad_o,
  output logic                                 last_o
);

  localparam int Steps = gtb_pkg::ExpSteps;
  localparam int Pw    = gtb_pkg::PWidth;
  localparam logic signed [gtb_pkg::SumWidth-1:0] SatMax =
    gtb_pkg::SumWidth'((1 << (gtb_pkg::DataWidth - 1)) - 1);
  localparam logic signed [gtb_pkg::SumWidth-1:0] SatMin = -SatMax - 1;

  // Range reduction.
  logic           r1_v_q, r2_v_q, r3_v_q;
  gtb_pkg::item_t r1_item_q, r2_item_q;
  logic [47:0]    r1_qm_q;
  logic [7:0]     r2_q0_q;
  logic [28:0]    r2_r0_q;
  gtb_pkg::exp_t  r3_c_q;
  logic [7:0]     q0_d;
  logic [28:0]    r0_d;
  logic           ge_ln2;
  gtb_pkg::exp_t  r3_c_d;

  always_comb begin
    q0_d   = r1_qm_q[47:gtb_pkg::RcpLn2Shift];
    r0_d   = 29'(36'(r1_item_q.mag) - 36'(q0_d) * 36'(gtb_pkg::Ln2Q));
    ge_ln2 = (r2_r0_q >= 29'(gtb_pkg::Ln2Q));
    r3_c_d.neg  = r2_item_q.neg;
    r3_c_d.k    = r2_q0_q + 8'(ge_ln2);
    r3_c_d.r    = ge_ln2 ? 28'(r2_r0_q - 29'(gtb_pkg::Ln2Q)) : r2_r0_q[27:0];
    r3_c_d.side = r2_item_q.side;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_v_q <= 1'b0;
      r2_v_q <= 1'b0;
      r3_v_q <= 1'b0;
    end else begin
      r1_v_q <= vld_i;
      r2_v_q <= r1_v_q;
      r3_v_q <= r2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_item_q <= item_i;
    r1_qm_q   <= 48'(item_i.mag) * 48'(gtb_pkg::RcpLn2);
    r2_item_q <= r1_item_q;
    r2_q0_q   <= q0_d;
    r2_r0_q   <= r0_d;
    r3_c_q    <= r3_c_d;
  end

  // Horner evaluation of exp(-r), three stages per term.
  logic          hv [Steps+1];
  gtb_pkg::exp_t hc [Steps+1];
  logic [Pw-1:0] hp [Steps+1];

  assign hv[0] = r3_v_q;
  assign hc[0] = r3_c_q;
  assign hp[0] = gtb_pkg::OneQ;

  for (genvar i = 0; i < Steps; i++) begin : g_horner
    localparam logic [3:0]  N = 4'(Steps - i);
    localparam logic [31:0] M = gtb_pkg::rcp_n(N);
    logic v1_q, v2_q, v3_q;
    gtb_pkg::exp_t c1_q, c2_q, c3_q;
    logic [Pw-1:0] t_q, vv_q, p_q;
    logic [60:0]   qm_q;
    logic [56:0]   prod;
    logic [Pw-1:0] t_d, vv_d, q0, q, p_d;
    logic [32:0]   rm;

    always_comb begin
      prod = 57'(hc[i].r) * 57'(hp[i]);
      t_d  = Pw'((prod + (57'(1) << (gtb_pkg::Iq - 1))) >> gtb_pkg::Iq);
      vv_d = t_q + Pw'(N >> 1);
      q0   = Pw'(qm_q >> gtb_pkg::RcpNShift);
      rm   = 33'(vv_q) - 33'(q0) * 33'(N);
      q    = q0 + Pw'(rm >= 33'(N));
      p_d  = gtb_pkg::OneQ - q;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v1_q <= 1'b0;
        v2_q <= 1'b0;
        v3_q <= 1'b0;
      end else begin
        v1_q <= hv[i];
        v2_q <= v1_q;
        v3_q <= v2_q;
      end
    end

    always_ff @(posedge clk_i) begin
      c1_q <= hc[i];
      t_q  <= t_d;
      c2_q <= c1_q;
      vv_q <= vv_d;
      qm_q <= 61'(vv_d) * 61'(M);
      c3_q <= c2_q;
      p_q  <= p_d;
    end

    assign hv[i+1] = v3_q;
    assign hc[i+1] = c3_q;
    assign hp[i+1] = p_q;
  end

  // Scale by two to the minus k, then form the sigmoid fraction.
  logic           x1_v_q, x2_v_q;
  logic           x1_neg_q;
  gtb_pkg::side_t x1_side_q, x2_side_q;
  logic [Pw-1:0]  x1_e_q;
  logic [gtb_pkg::NumWidth-1:0] x2_num_q;
  logic [gtb_pkg::DenWidth-1:0] x2_den_q;
  logic [Pw-1:0]  e_d;
  logic [gtb_pkg::KWidth-1:0] kk;
  logic [gtb_pkg::DenWidth-1:0] den_d;
  logic [gtb_pkg::NumWidth-1:0] num_d;

  always_comb begin
    kk = hc[Steps].k;
    priority if (kk >= 8'(gtb_pkg::ExpKLimit)) begin
      e_d = '0;
    end else if (kk == 8'd0) begin
      e_d = hp[Steps];
    end else begin
      e_d = Pw'((41'(hp[Steps]) + (41'(1) << (kk - 8'd1))) >> kk);
    end
    den_d = gtb_pkg::DenWidth'(gtb_pkg::OneQ) + gtb_pkg::DenWidth'(x1_e_q);
    num_d = x1_neg_q
          ? (57'(1) << (2 * gtb_pkg::Iq)) + 57'(den_d >> 1)
          : (57'(x1_e_q) << gtb_pkg::Iq) + 57'(den_d >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_v_q <= 1'b0;
      x2_v_q <= 1'b0;
    end else begin
      x1_v_q <= hv[Steps];
      x2_v_q <= x1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_e_q    <= e_d;
    x1_neg_q  <= hc[Steps].neg;
    x1_side_q <= hc[Steps].side;
    x2_num_q  <= num_d;
    x2_den_q  <= den_d;
    x2_side_q <= x1_side_q;
  end

  logic           dv;
  logic [Pw-1:0]  s_div;
  gtb_pkg::side_t dside;

  gtb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (x2_v_q),
    .num_i  (x2_num_q),
    .den_i  (x2_den_q),
    .side_i (x2_side_q),
    .vld_o  (dv),
    .quo_o  (s_div),
    .side_o (dside)
  );

  // Derivative, gradient product and accumulation.
  logic b1_v_q, b2_v_q, b3_v_q, b4_v_q, b5_v_q, done_q;
  gtb_pkg::side_t b1_side_q, b2_side_q, b3_side_q, b4_side_q, b5_side_q;
  logic [Pw-1:0] b1_s_q, b2_s_q;
  logic [46:0]   b1_pl_q, b3_pl_q;
  logic signed [48:0] b1_ph_q, b3_ph_q;
  logic signed [gtb_pkg::DerivWidth-1:0] b2_deriv_q;
  logic signed [gtb_pkg::GWidth-1:0] b4_g_q;
  logic signed [gtb_pkg::TermWidth-1:0] b5_term_q;
  logic signed [gtb_pkg::DataWidth-1:0] grad_q;
  logic last_q;

  logic [Pw-1:0] om;
  logic signed [66:0] prod1, prod2;
  logic signed [gtb_pkg::DerivWidth-1:0] deriv_d;
  logic signed [gtb_pkg::GWidth-1:0] g_d;
  logic signed [gtb_pkg::TermWidth-1:0] term_d;
  logic signed [gtb_pkg::SumWidth-1:0] sum;
  logic signed [gtb_pkg::DataWidth-1:0] grad_d;

  always_comb begin
    om      = gtb_pkg::OneQ - s_div;
    prod1   = (67'(b1_ph_q) <<< gtb_pkg::LoBits) + 67'($signed({1'b0, b1_pl_q}));
    deriv_d = gtb_pkg::DerivWidth'(gtb_pkg::OneQ)
            - gtb_pkg::DerivWidth'(gtb_pkg::rnd_q(80'(prod1), gtb_pkg::Iq));
    prod2   = (67'(b3_ph_q) <<< gtb_pkg::LoBits) + 67'($signed({1'b0, b3_pl_q}));
    g_d     = gtb_pkg::GWidth'(gtb_pkg::rnd_q(80'(prod2), gtb_pkg::Iq));
    term_d  = gtb_pkg::TermWidth'(gtb_pkg::rnd_q(
                80'(54'(b4_g_q) * 54'(b4_side_q.dy)), gtb_pkg::Iq));
    sum     = gtb_pkg::SumWidth'(b5_side_q.dx) + gtb_pkg::SumWidth'(b5_term_q);
    priority if (sum > SatMax) begin
      grad_d = SatMax[gtb_pkg::DataWidth-1:0];
    end else if (sum < SatMin) begin
      grad_d = SatMin[gtb_pkg::DataWidth-1:0];
    end else begin
      grad_d = sum[gtb_pkg::DataWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
      b3_v_q <= 1'b0;
      b4_v_q <= 1'b0;
      b5_v_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      b1_v_q <= dv;
      b2_v_q <= b1_v_q;
      b3_v_q <= b2_v_q;
      b4_v_q <= b3_v_q;
      b5_v_q <= b4_v_q;
      done_q <= b5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b1_side_q  <= dside;
    b1_s_q     <= s_div;
    b1_pl_q    <= 47'(dside.y2[gtb_pkg::LoBits-1:0]) * 47'(om);
    b1_ph_q    <= 49'($signed(dside.y2[gtb_pkg::Y2Width-1:gtb_pkg::LoBits]))
                * 49'($signed({1'b0, om}));
    b2_side_q  <= b1_side_q;
    b2_s_q     <= b1_s_q;
    b2_deriv_q <= deriv_d;
    b3_side_q  <= b2_side_q;
    b3_pl_q    <= 47'(b2_deriv_q[gtb_pkg::LoBits-1:0]) * 47'(b2_s_q);
    b3_ph_q    <= 49'($signed(b2_deriv_q[gtb_pkg::DerivWidth-1:gtb_pkg::LoBits]))
                * 49'($signed({1'b0, b2_s_q}));
    b4_side_q  <= b3_side_q;
    b4_g_q     <= g_d;
    b5_side_q  <= b4_side_q;
    b5_term_q  <= term_d;
    grad_q     <= grad_d;
    last_q     <= b5_side_q.last;
  end

  assign done_o = done_q;
  assign grad_o = grad_q;
  assign last_o = last_q;

endmodule
`default_nettype wire

@@ design/gelu_tanh_backward.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GeLU tanh backward
// Element-wise input gradient of the tanh-approximated GeLU in Q4.12.
//
//   Channel   Ports                                        Transfer
//   input     x_value_i, grad_out_i, grad_acc_in_i,        start && !busy
//             last_in_i
//   result    grad_acc_out_o, last_out_o                   done_o
//
// One item is taken every cycle while busy is low.
// The exponential series has 33 stages and the sigmoid divider 29 stages.
// Reset clears only the valid bits of the pipeline and the queue's pointers and count.
// The back end never stalls; busy rises only if the queue fills.
// ----------------------------------------------------------------------------
module gelu_tanh_backward (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [gtb_pkg::DataWidth-1:0] x_value_i,
  input  wire logic signed [gtb_pkg::DataWidth-1:0] grad_out_i,
  input  wire logic signed [gtb_pkg::DataWidth-1:0] grad_acc_in_i,
  input  wire logic                                  last_in_i,
  output logic                                       done_o,
  output logic signed [gtb_pkg::DataWidth-1:0]      grad_acc_out_o,
  output logic                                       last_out_o
);

  logic           push, pop, full, empty;
  gtb_pkg::item_t item_in, item_out;

  gtb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .x_i     (x_value_i),
    .dy_i    (grad_out_i),
    .dx_i    (grad_acc_in_i),
    .last_i  (last_in_i),
    .full_i  (full),
    .push_o  (push),
    .item_o  (item_in)
  );

  gtb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item_in),
    .pop_i   (pop),
    .item_o  (item_out),
    .full_o  (full),
    .empty_o (empty)
  );

  assign pop = !empty;

  gtb_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (pop),
    .item_i (item_out),
    .done_o (done_o),
    .grad_o (grad_acc_out_o),
    .last_o (last_out_o)
  );

endmodule
`default_nettype wire

@@ sim/gelu_tanh_backward_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GeLU tanh backward checker
// Watches the input and result channels of the block, computes the expected
// accumulated gradient of each accepted transfer with its own fixed-point
// model, and compares every result field by field against the oldest one.
// ----------------------------------------------------------------------------
module gelu_tanh_backward_checker (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start,
  input  wire logic                                  busy,
  input  wire logic signed [gtb_pkg::DataWidth-1:0] x_value_i,
  input  wire logic signed [gtb_pkg::DataWidth-1:0] grad_out_i,
  input  wire logic signed [gtb_pkg::DataWidth-1:0] grad_acc_in_i,
  input  wire logic                                  last_in_i,
  input  wire logic                                  done_o,
  input  wire logic signed [gtb_pkg::DataWidth-1:0] grad_acc_out_o,
  input  wire logic                                  last_out_o,
  output int                                         fail_count_o,
  output int                                         pending_o,
  output int                                         checked_o
);

  typedef struct {
    logic signed [gtb_pkg::DataWidth-1:0] grad;
    logic                                 last;
  } grad_result_t;

  localparam longint OneL  = longint'(1) << gtb_pkg::Iq;
  localparam longint K3L   = -64'sd428361012;
  localparam longint K4L   = -64'sd19154163;
  localparam longint K5L   = -64'sd57462488;
  localparam longint Ln2L  = 64'sd186065280;
  localparam longint XLimL = longint'(8) << gtb_pkg::Iq;

  grad_result_t grad_expected[$];

  function automatic longint round_iq(input longint v);
    longint unsigned mag;
    mag = (v < 0) ? longint'(-v) : v;
    mag = (mag + (longint'(1) << (gtb_pkg::Iq - 1))) >> gtb_pkg::Iq;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned exp_of_neg(input longint unsigned a);
    longint unsigned k, r, p, t;
    k = a / Ln2L;
    r = a - k * Ln2L;
    p = OneL;
    for (int n = gtb_pkg::ExpSteps; n >= 1; n--) begin
      t = (r * p + (longint'(1) << (gtb_pkg::Iq - 1))) >> gtb_pkg::Iq;
      p = OneL - (t + n / 2) / n;
    end
    if (k >= gtb_pkg::ExpKLimit) return 0;
    if (k == 0) return p;
    return (p + (longint'(1) << (k - 1))) >> k;
  endfunction

  function automatic logic signed [gtb_pkg::DataWidth-1:0] gelu_grad_acc(
      input logic signed [gtb_pkg::DataWidth-1:0] x,
      input logic signed [gtb_pkg::DataWidth-1:0] dy,
      input logic signed [gtb_pkg::DataWidth-1:0] dx);
    longint xi, z2, y1, y2, om, deriv, g, term, sum;
    longint maxv, minv;
    longint unsigned e, den, s;
    maxv = (longint'(1) << (gtb_pkg::DataWidth - 1)) - 1;
    minv = -maxv - 1;
    xi = longint'(x) <<< (gtb_pkg::Iq - gtb_pkg::FracBits);
    if (xi > XLimL) xi = XLimL;
    if (xi < -XLimL) xi = -XLimL;
    z2 = round_iq(xi * xi);
    y1 = round_iq(xi * (K3L + round_iq(K4L * z2)));
    y2 = round_iq(xi * (K3L + round_iq(K5L * z2)));
    if (y1 >= 0) begin
      e = exp_of_neg(y1);
      den = OneL + e;
      s = (e * OneL + den / 2) / den;
    end else begin
      e = exp_of_neg(-y1);
      den = OneL + e;
      s = (OneL * OneL + den / 2) / den;
    end
    om = OneL - longint'(s);
    deriv = OneL - round_iq(y2 * om);
    g = round_iq(deriv * longint'(s));
    term = round_iq(g * longint'(dy));
    sum = longint'(dx) + term;
    if (sum > maxv) sum = maxv;
    if (sum < minv) sum = minv;
    return sum[gtb_pkg::DataWidth-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    checked_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    grad_result_t exp_r;
    if (rst_ni) begin
      if (start && !busy) begin
        exp_r.grad = gelu_grad_acc(x_value_i, grad_out_i, grad_acc_in_i);
        exp_r.last = last_in_i;
        grad_expected.push_back(exp_r);
      end
      if (done_o) begin
        if (grad_expected.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          exp_r = grad_expected.pop_front();
          checked_o++;
          if (grad_acc_out_o !== exp_r.grad)
            report_mismatch($sformatf("grad_acc_out %0d, expected %0d",
                                      grad_acc_out_o, exp_r.grad));
          if (last_out_o !== exp_r.last)
            report_mismatch($sformatf("last_out %0b, expected %0b",
                                      last_out_o, exp_r.last));
        end
      end
      pending_o = grad_expected.size();
    end
  end

endmodule

@@ sim/gelu_tanh_backward_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GeLU tanh backward testbench
// Drives directed corner values and random Q4.12 elements into the block
// with random start gaps (none in part of the random run), and gives the verdict from the checker's counts.
// ----------------------------------------------------------------------------
module gelu_tanh_backward_tb;

  localparam int NumRandom = 1200;
  localparam int IdleLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [gtb_pkg::DataWidth-1:0] x_value_i = '0;
  logic signed [gtb_pkg::DataWidth-1:0] grad_out_i = '0;
  logic signed [gtb_pkg::DataWidth-1:0] grad_acc_in_i = '0;
  logic last_in_i = 1'b0;
  logic done_o;
  logic signed [gtb_pkg::DataWidth-1:0] grad_acc_out_o;
  logic last_out_o;
  int fail_count, pending, checked;
  int sent = 0;
  int quiet_cycles = 0;
  bit no_gaps = 1'b0;

  always #1 clk_i = ~clk_i;

  gelu_tanh_backward DUT (.*);

  gelu_tanh_backward_checker u_checker (
    .*,
    .fail_count_o(fail_count),
    .pending_o(pending),
    .checked_o(checked)
  );

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("gelu_tanh_backward regression: fail");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_element(input logic signed [gtb_pkg::DataWidth-1:0] x,
                              input logic signed [gtb_pkg::DataWidth-1:0] dy,
                              input logic signed [gtb_pkg::DataWidth-1:0] dx,
                              input logic l);
    while (!no_gaps && $urandom_range(99) < 15) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    x_value_i = x;
    grad_out_i = dy;
    grad_acc_in_i = dx;
    last_in_i = l;
    while (busy) @(negedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  function automatic logic signed [gtb_pkg::DataWidth-1:0] rand_field();
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return gtb_pkg::DataWidth'($signed($urandom_range(8192)) - 4096);
      default: return gtb_pkg::DataWidth'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [gtb_pkg::DataWidth-1:0] xv;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_element(16'sh0000, 16'sh1000, 16'sh0000, 1'b0);
    send_element(16'sh7fff, 16'sh1000, 16'sh0000, 1'b0);
    send_element(16'sh8000, 16'sh7fff, 16'sh1234, 1'b1);
    send_element(16'sh0001, 16'sh7fff, 16'sh7fff, 1'b0);
    send_element(16'shffff, 16'sh8000, 16'sh8000, 1'b1);
    send_element(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    send_element(16'sh7fff, 16'sh8000, 16'sh8000, 1'b0);
    send_element(-16'sd24576, 16'sh7fff, -16'sd100, 1'b0);
    send_element(-16'sd16384, 16'sh7fff, 16'sh0000, 1'b1);
    send_element(16'sd16384, 16'sh8000, 16'sh0000, 1'b0);
    send_element(16'sd4096, 16'sh1000, 16'sh1000, 1'b0);
    send_element(-16'sd4096, 16'sh1000, 16'shf000, 1'b1);
    send_element(16'sd2048, 16'sh7fff, 16'sh7000, 1'b0);
    send_element(-16'sd2048, 16'sh8000, 16'sh8800, 1'b0);
    send_element(16'sd8192, 16'sh5555, 16'shaaaa, 1'b1);
    send_element(16'sh0000, 16'sh0000, 16'sh0000, 1'b0);

    for (int i = 0; i < NumRandom; i++) begin
      no_gaps = (i >= 400 && i < 700);
      if ($urandom_range(3) == 0) xv = gtb_pkg::DataWidth'($urandom);
      else xv = gtb_pkg::DataWidth'($signed($urandom_range(40000)) - 20000);
      send_element(xv, rand_field(), rand_field(), 1'($urandom));
    end
    start = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);

    $display("Sent %0d elements, directed corners and random Q4.12 values,", sent);
    $display("with random start gaps; %0d results were checked.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("gelu_tanh_backward regression: pass");
    end else begin
      $display("gelu_tanh_backward regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/gtb_pkg.sv
design/gtb_front.sv
design/gtb_fifo.sv
design/gtb_div.sv
design/gtb_back.sv
design/gelu_tanh_backward.sv
sim/gelu_tanh_backward_checker.sv
sim/gelu_tanh_backward_tb.sv
